// File: rtl/adckpc_pkg.sv
// ----------------------------------------------------------------------------
// adckpc_pkg
// Shared types and constants for the ADC key press classifier.
// ----------------------------------------------------------------------------
package adckpc_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] RST_RELEASE_FLOOR = 16'd1;
  localparam logic [15:0] RST_BASELINE_TOL  = 16'd8;
  localparam logic [3:0]  RST_AGREE_SAMPLES = 4'd3;
  localparam logic [15:0] RST_LONG_HOLD_MS  = 16'd1500;
  localparam logic [15:0] RST_SHORT_HOLD_MS = 16'd400;

  typedef enum logic [1:0] {
    EV_SHORT  = 2'd0,
    EV_MEDIUM = 2'd1,
    EV_LONG   = 2'd2,
    EV_ERROR  = 2'd3
  } ev_code_t;

  typedef enum logic [2:0] {
    REG_RELEASE_FLOOR = 3'd0,
    REG_BASELINE_TOL  = 3'd1,
    REG_AGREE_SAMPLES = 3'd2,
    REG_LONG_HOLD_MS  = 3'd3,
    REG_SHORT_HOLD_MS = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_POLL   = 1'b1
  } req_t;

  typedef struct packed {
    logic [15:0] release_floor;
    logic [15:0] baseline_tol;
    logic [3:0]  agree_samples;
    logic [15:0] long_hold_ms;
    logic [15:0] short_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] adc_value;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic     push;
    ev_code_t code;
  } push_t;

  typedef struct packed {
    logic        event_valid;
    logic [1:0]  event_code;
    logic        error_code;
  } result_t;

endpackage

// File: rtl/adckpc_cfg.sv
// ----------------------------------------------------------------------------
// adckpc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module adckpc_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output adckpc_pkg::cfg_t   cfg_o
);
  import adckpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RELEASE_FLOOR: cfg_nxt.release_floor = cfg_wdata;
        REG_BASELINE_TOL:  cfg_nxt.baseline_tol  = cfg_wdata;
        REG_AGREE_SAMPLES: cfg_nxt.agree_samples = cfg_wdata[3:0];
        REG_LONG_HOLD_MS:  cfg_nxt.long_hold_ms  = cfg_wdata;
        REG_SHORT_HOLD_MS: cfg_nxt.short_hold_ms = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.release_floor <= RST_RELEASE_FLOOR;
      cfg_r.baseline_tol  <= RST_BASELINE_TOL;
      cfg_r.agree_samples <= RST_AGREE_SAMPLES;
      cfg_r.long_hold_ms  <= RST_LONG_HOLD_MS;
      cfg_r.short_hold_ms <= RST_SHORT_HOLD_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: rtl/adckpc_in_reg.sv
// ----------------------------------------------------------------------------
// adckpc_in_reg
// Input register stage: captures one item per cycle unless the stage holds.
// ----------------------------------------------------------------------------
module adckpc_in_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  hold,
  input  adckpc_pkg::in_item_t  item_i,
  output logic                  stage_valid,
  output adckpc_pkg::in_item_t  stage_item
);
  import adckpc_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!hold) begin
      valid_r <= in_valid;
    end
  end

  // Payload needs no reset; load only on a new item.
  always_ff @(posedge clk) begin
    if (!hold && in_valid) begin
      item_r <= item_i;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule

// File: rtl/adckpc_detect.sv
// ----------------------------------------------------------------------------
// adckpc_detect
// Calibration, debounced press detection and event classification.
// ----------------------------------------------------------------------------
module adckpc_detect (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                sample_en,
  input  logic [15:0]         adc_value,
  input  logic [31:0]         time_ms,
  input  adckpc_pkg::cfg_t    cfg,
  input  logic                fifo_full,
  output adckpc_pkg::push_t   push_o
);
  import adckpc_pkg::*;

  logic        calibrated_r, calibrated_nxt;
  logic        key_down_r, key_down_nxt;
  logic        long_rep_r, long_rep_nxt;
  logic        cand_r, cand_nxt;
  logic [15:0] base_r, base_nxt;
  logic [3:0]  agree_r, agree_nxt;
  logic [31:0] press_time_r, press_time_nxt;

  logic [15:0] dev;
  logic [3:0]  agree_inc;
  logic [17:0] base_x3;
  logic        pressed;
  logic [31:0] elapsed;
  push_t       push;

  assign dev       = (adc_value > base_r) ? (adc_value - base_r) : (base_r - adc_value);
  assign agree_inc = agree_r + 4'd1;
  assign base_x3   = {2'b00, base_r} + {1'b0, base_r, 1'b0};
  assign pressed   = key_down_r ? (adc_value < base_x3[17:2])
                                : (adc_value <= {2'b00, base_r[15:2]});
  // A press taken on this sample starts the hold at zero.
  assign elapsed   = (pressed && !key_down_r) ? 32'd0 : (time_ms - press_time_r);

  always_comb begin
    calibrated_nxt = calibrated_r;
    key_down_nxt   = key_down_r;
    long_rep_nxt   = long_rep_r;
    cand_nxt       = cand_r;
    base_nxt       = base_r;
    agree_nxt      = agree_r;
    press_time_nxt = press_time_r;
    push           = '{push: 1'b0, code: EV_SHORT};

    if (sample_en) begin
      if (!calibrated_r) begin
        if (adc_value < cfg.release_floor) begin
          agree_nxt = 4'd0;
        end else if (agree_r == 4'd0 || dev > cfg.baseline_tol) begin
          base_nxt  = adc_value;
          agree_nxt = 4'd1;
        end else if (agree_inc >= cfg.agree_samples) begin
          calibrated_nxt = 1'b1;
          agree_nxt      = 4'd0;
        end else begin
          agree_nxt = agree_inc;
        end
      end else begin
        if (pressed != cand_r) begin
          cand_nxt  = pressed;
          agree_nxt = 4'd1;
        end else if (agree_r < cfg.agree_samples) begin
          agree_nxt = agree_inc;
        end

        if (agree_nxt >= cfg.agree_samples) begin
          if (pressed && !key_down_r) begin
            key_down_nxt   = 1'b1;
            long_rep_nxt   = 1'b0;
            press_time_nxt = time_ms;
          end
          if (key_down_nxt && !long_rep_nxt && elapsed >= {16'd0, cfg.long_hold_ms}) begin
            push         = '{push: 1'b1, code: EV_LONG};
            long_rep_nxt = 1'b1;
          end
          if (!pressed && key_down_nxt) begin
            key_down_nxt = 1'b0;
            if (!long_rep_nxt) begin
              push = '{push: 1'b1,
                       code: (elapsed < {16'd0, cfg.short_hold_ms}) ? EV_SHORT : EV_MEDIUM};
            end
          end
        end
      end

      // Queue overflow: drop back to calibration.
      if (push.push && fifo_full) begin
        calibrated_nxt = 1'b0;
        key_down_nxt   = 1'b0;
        long_rep_nxt   = 1'b0;
        cand_nxt       = 1'b0;
        base_nxt       = 16'd0;
        agree_nxt      = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calibrated_r <= 1'b0;
      key_down_r   <= 1'b0;
      long_rep_r   <= 1'b0;
      cand_r       <= 1'b0;
      base_r       <= 16'd0;
      agree_r      <= 4'd0;
      press_time_r <= 32'd0;
    end else begin
      calibrated_r <= calibrated_nxt;
      key_down_r   <= key_down_nxt;
      long_rep_r   <= long_rep_nxt;
      cand_r       <= cand_nxt;
      base_r       <= base_nxt;
      agree_r      <= agree_nxt;
      press_time_r <= press_time_nxt;
    end
  end

  assign push_o = push;

endmodule

// File: rtl/adckpc_fifo.sv
// ----------------------------------------------------------------------------
// adckpc_fifo
// Event queue with sticky overflow error and restart to a single ERROR entry.
// ----------------------------------------------------------------------------
module adckpc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  adckpc_pkg::push_t    push_i,
  input  logic                 pop,
  output logic                 full,
  output adckpc_pkg::result_t  pop_result
);
  import adckpc_pkg::*;

  localparam int SUM_W = PTR_W + 1;

  ev_code_t          entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              err_r, err_nxt;

  logic [SUM_W-1:0]  wr_sum;
  logic [PTR_W-1:0]  wr_addr;
  logic              restart;
  logic              do_push;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign restart = push_i.push && full;
  assign do_push = push_i.push && !full;
  assign wr_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign wr_addr = (wr_sum >= SUM_W'(QUEUE_DEPTH)) ? PTR_W'(wr_sum - SUM_W'(QUEUE_DEPTH))
                                                     : PTR_W'(wr_sum);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    if (restart) begin
      head_nxt  = '0;
      count_nxt = CNT_W'(1);
      err_nxt   = 1'b1;
    end else if (do_push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && count_r != '0) begin
      head_nxt  = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      err_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (restart) begin
      entries_r[0] <= EV_ERROR;
    end else if (do_push) begin
      entries_r[wr_addr] <= push_i.code;
    end
  end

  always_comb begin
    pop_result.event_valid = (count_r != '0);
    pop_result.event_code  = (count_r != '0) ? entries_r[head_r] : EV_SHORT;
    pop_result.error_code  = err_r;
  end

endmodule

// File: rtl/adckpc_out_reg.sv
// ----------------------------------------------------------------------------
// adckpc_out_reg
// Result register: holds a poll result until the receiver takes it.
// ----------------------------------------------------------------------------
module adckpc_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  adckpc_pkg::result_t  result_i,
  input  logic                 out_stall,
  output logic                 out_valid,
  output adckpc_pkg::result_t  result_o
);
  import adckpc_pkg::*;

  logic    valid_r;
  result_t result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_i;
    end
  end

  assign out_valid = valid_r;
  assign result_o  = result_r;

endmodule

// File: rtl/adc_key_press_classifier.sv
// ----------------------------------------------------------------------------
// adc_key_press_classifier
// Debounced ADC key classifier with short, medium and long press events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): each item is either an ADC sample
//   (in_req_type = 0, with in_adc_value and in_time_ms) or a poll
//   (in_req_type = 1). Samples produce no result; each poll produces one.
//   Result channel (out_valid / out_stall): out_event_valid tells whether an
//   event was popped, out_event_code carries it, out_error_code shows the
//   sticky queue overflow flag.
//   Configuration: write cfg_wdata into register cfg_index while cfg_wr_en
//   is high; indexes past the register list are ignored. Write only while
//   the block is idle.
// Timing: one item per cycle while in_stall is low. An item is registered on
//   acceptance, processed from the input stage, and a poll result is then
//   registered in the output register, which raises out_valid. The rate
//   holds as the state update between the two registers is combinational.
// Reset: rst_n clears all control state: uncalibrated, queue empty, no error,
//   registers at their defaults.
// Stall: while a result waits in the output register and out_stall is high,
//   samples still flow; a poll in the stage holds and in_stall rises.
// ----------------------------------------------------------------------------
module adc_key_press_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [15:0] in_adc_value,
  input  logic [31:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_event_valid,
  output logic [1:0]  out_event_code,
  output logic        out_error_code,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import adckpc_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  in_item_t stage_item;
  logic     stage_valid;
  logic     stage_poll;
  logic     advance;
  logic     sample_en;
  logic     pop;
  logic     fifo_full;
  push_t    push;
  result_t  pop_result;
  result_t  out_result;

  adckpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  assign in_item = '{req_type: in_req_type, adc_value: in_adc_value, time_ms: in_time_ms};

  // Hold a poll only while the output register is full and stalled.
  assign stage_poll = stage_valid && (stage_item.req_type == REQ_POLL);
  assign advance    = !(stage_poll && out_valid && out_stall);
  assign in_stall   = stage_valid && !advance;
  assign sample_en  = stage_valid && (stage_item.req_type == REQ_SAMPLE);
  assign pop        = stage_poll && advance;

  adckpc_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .hold        (in_stall),
    .item_i      (in_item),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  adckpc_detect u_detect (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .adc_value (stage_item.adc_value),
    .time_ms   (stage_item.time_ms),
    .cfg       (cfg),
    .fifo_full (fifo_full),
    .push_o    (push)
  );

  adckpc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .pop        (pop),
    .full       (fifo_full),
    .pop_result (pop_result)
  );

  adckpc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (pop),
    .result_i  (pop_result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .result_o  (out_result)
  );

  assign out_event_valid = out_result.event_valid;
  assign out_event_code  = out_result.event_code;
  assign out_error_code  = out_result.error_code;

  // An empty poll reports the short code.
  a_empty_code : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_event_valid) |-> (out_event_code == EV_SHORT))
    else $error("empty poll result carries a nonzero event code");

  // Overflow error never clears once reported.
  a_err_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code) |=> out_error_code)
    else $error("sticky error cleared");

  // A held poll stays in the stage.
  a_hold_keeps : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> (stage_valid && stage_item.req_type == REQ_POLL))
    else $error("held poll lost from the stage");

endmodule
